/* rtl/dvrt_pkg.sv */
// shared types, widths and codes for the distance vector route table
// no dependencies; imported by the interfaces, the top level and the testbench

package dvrt_pkg;

   localparam int TABLE_ENTRIES = 8;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int ADDR_W        = 32;
   localparam int PREFIX_W      = 6;
   localparam int DIST_W        = 32;
   localparam int AGE_W         = 8;
   localparam int CMD_W         = 2;
   localparam int KIND_W        = 2;
   localparam int STATUS_W      = 2;
   localparam int SLOT_W        = 3;
   localparam int CNT_W         = 4;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 8;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [AGE_W-1:0] AGE_MAX  = '1;
   localparam logic [CNT_W-1:0] CNT_MAX  = '1;

   localparam logic [CSR_IDX_W-1:0]  CSR_DIRECT_AGE_LIMIT   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0]  CSR_INDIRECT_AGE_LIMIT = CSR_IDX_W'(1);
   localparam logic [CSR_DATA_W-1:0] DIRECT_AGE_RESET       = CSR_DATA_W'(4);
   localparam logic [CSR_DATA_W-1:0] INDIRECT_AGE_RESET     = CSR_DATA_W'(2);

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD   = 2'd0,
      CMD_INVAL = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_FREE    = 2'd0,
      KIND_DIRECT  = 2'd1,
      KIND_VIA     = 2'd2,
      KIND_UNREACH = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_MATCH  = 2'd0,
      ST_STORED = 2'd1,
      ST_FULL   = 2'd2,
      ST_DONE   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EXEC,
      S_CREAD,
      S_CEXEC,
      S_FILL,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   dest_ip;
      logic [PREFIX_W-1:0] prefix;
      logic [ADDR_W-1:0]   next_hop;
      logic [DIST_W-1:0]   distance;
      kind_type            kind;
      logic [AGE_W-1:0]    age;
   } entry_type;

endpackage

/* rtl/dvrt_req_if.sv */
// request channel: command and route fields with valid/ready
// depends on dvrt_pkg for field widths

interface dvrt_req_if;
   import dvrt_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [ADDR_W-1:0]   dest_ip;
   logic [PREFIX_W-1:0] dest_prefix;
   logic [ADDR_W-1:0]   next_hop_ip;
   logic [DIST_W-1:0]   route_distance;
   logic [KIND_W-1:0]   route_kind;
   logic [AGE_W-1:0]    initial_age;

   modport source (
      output valid, command, dest_ip, dest_prefix, next_hop_ip,
             route_distance, route_kind, initial_age,
      input  ready
   );
   modport sink (
      input  valid, command, dest_ip, dest_prefix, next_hop_ip,
             route_distance, route_kind, initial_age,
      output ready
   );
endinterface

/* rtl/dvrt_rsp_if.sv */
// response channel: status, slot and change count with valid/ready
// depends on dvrt_pkg for field widths

interface dvrt_rsp_if;
   import dvrt_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot_index;
   logic [CNT_W-1:0]    changed_count;

   modport source (
      output valid, status, slot_index, changed_count,
      input  ready
   );
   modport sink (
      input  valid, status, slot_index, changed_count,
      output ready
   );
endinterface

/* rtl/distance_vector_route_table.sv */
// distance vector route table: top level with sequencer, entry update unit and table ram
// depends on dvrt_pkg, dvrt_req_if, dvrt_rsp_if and dvrt_ram
//
// channel   direction  transaction
// req_bus   in         one command: add, invalidate, tick or none (with route fields)
// rsp_bus   out        one result per command: status, slot_index, changed_count
// csr_*     in         limit register write, taken on any cycle with csr_we
//
// every entry visit goes through the single table read port: a read state, then an update state
// add: scan up to the match (or all), fill a free slot if none matched and one is free, respond
// invalidate and tick: scan all entries, a full cascade scan per direct route dropped, respond
// reset clears one valid bit per entry at once; an entry never written reads as all zero
// one command at a time: req ready only when idle, result held until rsp ready

module distance_vector_route_table (
   input  logic                          clock,
   input  logic                          reset,
   dvrt_req_if.sink                      req_bus,
   dvrt_rsp_if.source                    rsp_bus,
   input  logic                          csr_we,
   input  logic [dvrt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dvrt_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dvrt_pkg::*;

   // sequencer and datapath registers
   state_type           state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   entry_type           new_ff, new_in;         // route carried by an add, match key of an invalidate
   logic [IDX_W-1:0]    idx_ff, idx_in;         // outer table scan
   logic [IDX_W-1:0]    cidx_ff, cidx_in;       // cascade scan
   logic [ADDR_W-1:0]   hop_ff, hop_in;         // address whose routes get freed
   logic                have_free_ff, have_free_in;
   logic [IDX_W-1:0]    free_ff, free_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   status_type          status_ff, status_in;
   logic [IDX_W-1:0]    slot_ff, slot_in;
   logic [CSR_DATA_W-1:0] direct_lim_ff;
   logic [CSR_DATA_W-1:0] indirect_lim_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff;

   // table ram port
   logic                ram_we;
   logic [IDX_W-1:0]    ram_waddr;
   entry_type           ram_wdata;
   logic [IDX_W-1:0]    ram_raddr;
   logic [$bits(entry_type)-1:0] ram_rdata;

   // shared entry update unit
   logic [IDX_W-1:0]    cur_addr;
   entry_type           cur;
   logic                req_accept;
   logic                add_hit, add_take, free_now;
   logic                inv_hit, too_old, drop, drop_direct, drop_via;
   logic                hop_hit;
   logic [AGE_W-1:0]    aged;
   logic [CNT_W-1:0]    cnt_inc;
   logic                idx_last, cidx_last;

   assign req_accept = req_bus.valid && req_bus.ready;

   // cascade uses its own pointer; everything else walks the outer pointer
   assign cur_addr  = (state_ff == S_CREAD || state_ff == S_CEXEC) ? cidx_ff : idx_ff;
   assign ram_raddr = cur_addr;
   assign cur       = valid_ff[cur_addr] ? entry_type'(ram_rdata) : entry_type'('0);
   assign idx_last  = (idx_ff == LAST_IDX);
   assign cidx_last = (cidx_ff == LAST_IDX);

   // compare and update decisions for the entry just read
   always_comb begin
      add_hit  = (cur.dest_ip == new_ff.dest_ip);
      add_take = (cur.distance >= new_ff.distance) || (cur.kind == KIND_UNREACH) ||
                 (cur.next_hop == new_ff.next_hop);
      free_now = have_free_ff || (cur.kind == KIND_FREE);
      inv_hit  = (cur.dest_ip == new_ff.dest_ip) && (cur.prefix == new_ff.prefix);
      aged     = (cur.age == AGE_MAX) ? cur.age : cur.age + AGE_W'(1);
      too_old  = ((cur.kind == KIND_DIRECT) && (aged > direct_lim_ff)) ||
                 ((cur.kind == KIND_VIA) && (aged > indirect_lim_ff));
      priority case (cmd_ff)
         CMD_INVAL: drop = inv_hit;
         CMD_TICK:  drop = too_old;
         default:   drop = 1'b0;
      endcase
      drop_direct = drop && (cur.kind == KIND_DIRECT);
      drop_via    = drop && (cur.kind == KIND_VIA);
      hop_hit     = (cur.kind == KIND_VIA) && (cur.next_hop == hop_ff);
      cnt_inc     = (cnt_ff == CNT_MAX) ? cnt_ff : cnt_ff + CNT_W'(1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = (cmd_type'(req_bus.command) == CMD_NONE) ? S_RESP : S_READ;
            end
         end
         S_READ: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (cmd_ff == CMD_ADD) begin
               if (add_hit) begin
                  state_in = S_RESP;
               end else if (idx_last) begin
                  state_in = free_now ? S_FILL : S_RESP;
               end else begin
                  state_in = S_READ;
               end
            end else if (drop_direct) begin
               state_in = S_CREAD;
            end else begin
               state_in = idx_last ? S_RESP : S_READ;
            end
         end
         S_CREAD: begin
            state_in = S_CEXEC;
         end
         S_CEXEC: begin
            if (!cidx_last) begin
               state_in = S_CREAD;
            end else begin
               state_in = idx_last ? S_RESP : S_READ;
            end
         end
         S_FILL: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_bus.ready) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // datapath and table writes
   always_comb begin
      cmd_in       = cmd_ff;
      new_in       = new_ff;
      idx_in       = idx_ff;
      cidx_in      = cidx_ff;
      hop_in       = hop_ff;
      have_free_in = have_free_ff;
      free_in      = free_ff;
      cnt_in       = cnt_ff;
      status_in    = status_ff;
      slot_in      = slot_ff;
      ram_we       = 1'b0;
      ram_waddr    = cur_addr;
      ram_wdata    = cur;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cmd_in          = cmd_type'(req_bus.command);
               new_in.dest_ip  = req_bus.dest_ip;
               new_in.prefix   = req_bus.dest_prefix;
               new_in.next_hop = req_bus.next_hop_ip;
               new_in.distance = req_bus.route_distance;
               new_in.kind     = kind_type'(req_bus.route_kind);
               new_in.age      = req_bus.initial_age;
               idx_in          = '0;
               cidx_in         = '0;
               have_free_in    = 1'b0;
               free_in         = '0;
               cnt_in          = '0;
               status_in       = ST_DONE;
               slot_in         = '0;
            end
         end
         S_EXEC: begin
            if (cmd_ff == CMD_ADD) begin
               if (add_hit) begin
                  status_in = ST_MATCH;
                  slot_in   = idx_ff;
                  if (add_take) begin
                     ram_we    = 1'b1;
                     ram_wdata = new_ff;
                     if (new_ff.kind != cur.kind) begin
                        cnt_in = cnt_inc;
                     end
                  end
               end else begin
                  if (cur.kind == KIND_FREE) begin
                     have_free_in = 1'b1;
                     free_in      = idx_ff;
                  end
                  if (idx_last) begin
                     if (!free_now) begin
                        status_in = ST_FULL;
                     end
                  end else begin
                     idx_in = idx_ff + IDX_W'(1);
                  end
               end
            end else begin
               // invalidate or tick: tick always writes back the aged entry
               ram_we = (cmd_ff == CMD_TICK) || drop;
               if (cmd_ff == CMD_TICK) begin
                  ram_wdata.age = aged;
               end
               if (drop_direct) begin
                  ram_wdata.distance = '1;
                  ram_wdata.kind     = KIND_UNREACH;
                  cnt_in             = cnt_inc;
                  hop_in             = cur.dest_ip;
                  cidx_in            = '0;
               end else begin
                  if (drop_via) begin
                     ram_wdata.kind = KIND_FREE;
                     cnt_in         = cnt_inc;
                  end
                  if (!idx_last) begin
                     idx_in = idx_ff + IDX_W'(1);
                  end
               end
            end
         end
         S_CEXEC: begin
            if (hop_hit) begin
               ram_we         = 1'b1;
               ram_wdata.kind = KIND_FREE;
               cnt_in         = cnt_inc;
            end
            if (!cidx_last) begin
               cidx_in = cidx_ff + IDX_W'(1);
            end else if (!idx_last) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_FILL: begin
            ram_we    = 1'b1;
            ram_waddr = free_ff;
            ram_wdata = new_ff;
            status_in = ST_STORED;
            slot_in   = free_ff;
            if (new_ff.kind != KIND_FREE) begin
               cnt_in = cnt_inc;
            end
         end
         S_READ, S_CREAD, S_RESP: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         valid_ff        <= '0;
         direct_lim_ff   <= DIRECT_AGE_RESET;
         indirect_lim_ff <= INDIRECT_AGE_RESET;
      end else begin
         state_ff <= state_in;
         if (ram_we) begin
            valid_ff[ram_waddr] <= 1'b1;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_DIRECT_AGE_LIMIT:   direct_lim_ff   <= csr_wdata;
               CSR_INDIRECT_AGE_LIMIT: indirect_lim_ff <= csr_wdata;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      new_ff       <= new_in;
      idx_ff       <= idx_in;
      cidx_ff      <= cidx_in;
      hop_ff       <= hop_in;
      have_free_ff <= have_free_in;
      free_ff      <= free_in;
      cnt_ff       <= cnt_in;
      status_ff    <= status_in;
      slot_ff      <= slot_in;
   end

   dvrt_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_bus.ready         = (state_ff == S_IDLE);
   assign rsp_bus.valid         = (state_ff == S_RESP);
   assign rsp_bus.status        = status_ff;
   assign rsp_bus.slot_index    = SLOT_W'(slot_ff);
   assign rsp_bus.changed_count = cnt_ff;

   // one transaction in flight: never ready while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> !rsp_bus.valid)
      else $error("request ready while a result is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_bus.ready)
      else $error("request taken while a command is still running");

   // the cascade pass only ever frees routes
   a_cascade_frees: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CEXEC && ram_we) |-> (ram_wdata.kind == KIND_FREE))
      else $error("cascade wrote a kind other than free");

   a_full_untouched: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status == ST_FULL) |->
         (rsp_bus.changed_count == '0 && rsp_bus.slot_index == '0))
      else $error("full table reported with a change or a slot");
endmodule

/* rtl/dvrt_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies

module dvrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* verif/tb_distance_vector_route_table.sv */
// self-checking testbench for the distance vector route table: directed and random commands
// depends on dvrt_pkg, dvrt_req_if, dvrt_rsp_if and the distance_vector_route_table rtl
`timescale 1ns / 1ps

module tb_distance_vector_route_table;
   import dvrt_pkg::*;

   localparam int STALL_LIMIT_CYCLES = 2000;  // no transaction for this long means a hang
   localparam int CONFIG_SETTLE      = 4;     // pause before a limit write
   localparam int END_SETTLE         = 160;   // settle after the final drain, before the verdict
   localparam int RANDOM_PHASES      = 8;
   localparam int PHASE_ITEMS        = 230;

   // one command as driven on the request channel
   typedef struct {
      cmd_type             command;
      logic [ADDR_W-1:0]   dest_ip;
      logic [PREFIX_W-1:0] dest_prefix;
      logic [ADDR_W-1:0]   next_hop_ip;
      logic [DIST_W-1:0]   route_distance;
      kind_type            route_kind;
      logic [AGE_W-1:0]    initial_age;
   } route_cmd_type;

   // one response as expected on the result channel
   typedef struct {
      status_type        status;
      logic [SLOT_W-1:0] slot;
      logic [CNT_W-1:0]  changed;
   } route_result_type;

   logic clock;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dvrt_req_if req_bus ();
   dvrt_rsp_if rsp_bus ();

   distance_vector_route_table uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the route table and its limit registers
   logic [ADDR_W-1:0]   tbl_dest   [TABLE_ENTRIES];
   logic [PREFIX_W-1:0] tbl_prefix [TABLE_ENTRIES];
   logic [ADDR_W-1:0]   tbl_hop    [TABLE_ENTRIES];
   logic [DIST_W-1:0]   tbl_dist   [TABLE_ENTRIES];
   kind_type            tbl_kind   [TABLE_ENTRIES];
   logic [AGE_W-1:0]    tbl_age    [TABLE_ENTRIES];
   logic [AGE_W-1:0]    direct_limit;
   logic [AGE_W-1:0]    indirect_limit;

   route_result_type pending_results[$];   // responses still owed by the block, oldest first
   int mismatch_count;
   int sender_idle_pct;
   int receiver_stall_pct;
   int quiet_cycles;

   // clock, 4 ns period
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // table prediction
   // ---------------------------------------------------------------------------------------

   // every via route whose next hop is this address goes back to free
   function automatic void clear_routes_via(input logic [ADDR_W-1:0] hop);
      for (int j = 0; j < TABLE_ENTRIES; j++) begin
         if (tbl_kind[j] == KIND_VIA && tbl_hop[j] == hop) tbl_kind[j] = KIND_FREE;
      end
   endfunction

   // direct route: unreachable with infinite distance, dependents freed; via route: freed
   function automatic void retire_route(input int i);
      if (tbl_kind[i] == KIND_DIRECT) begin
         tbl_dist[i] = '1;
         tbl_kind[i] = KIND_UNREACH;
         clear_routes_via(tbl_dest[i]);
      end else if (tbl_kind[i] == KIND_VIA) begin
         tbl_kind[i] = KIND_FREE;
      end
   endfunction

   function automatic void store_route(input int i, input route_cmd_type c);
      tbl_dest[i]   = c.dest_ip;
      tbl_prefix[i] = c.dest_prefix;
      tbl_hop[i]    = c.next_hop_ip;
      tbl_dist[i]   = c.route_distance;
      tbl_kind[i]   = c.route_kind;
      tbl_age[i]    = c.initial_age;
   endfunction

   // applies one command to the shadow table and returns the response it must produce
   function automatic route_result_type predict_route_result(input route_cmd_type c);
      route_result_type r;
      kind_type      prior[TABLE_ENTRIES];
      bit            matched;
      bit            have_free;
      bit            expired;
      int            free_slot;
      r.status  = ST_DONE;
      r.slot    = '0;
      r.changed = '0;
      matched   = 1'b0;
      have_free = 1'b0;
      free_slot = 0;
      foreach (prior[i]) prior[i] = tbl_kind[i];
      case (c.command)
         CMD_ADD: begin
            // first address match wins, free entries included, prefix ignored
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (!matched) begin
                  if (tbl_dest[i] == c.dest_ip) begin
                     if (tbl_dist[i] >= c.route_distance || tbl_kind[i] == KIND_UNREACH ||
                         tbl_hop[i] == c.next_hop_ip)
                        store_route(i, c);
                     matched  = 1'b1;
                     r.status = ST_MATCH;
                     r.slot   = SLOT_W'(i);
                  end else if (tbl_kind[i] == KIND_FREE) begin
                     have_free = 1'b1;
                     free_slot = i;
                  end
               end
            end
            // no match: highest numbered free entry, or table full
            if (!matched) begin
               if (have_free) begin
                  store_route(free_slot, c);
                  r.status = ST_STORED;
                  r.slot   = SLOT_W'(free_slot);
               end else begin
                  r.status = ST_FULL;
               end
            end
         end
         CMD_INVAL: begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (tbl_dest[i] == c.dest_ip && tbl_prefix[i] == c.dest_prefix) retire_route(i);
            end
         end
         CMD_TICK: begin
            // age and expire in index order, a cascade can free later entries first
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (tbl_age[i] != AGE_MAX) tbl_age[i] = tbl_age[i] + 1'b1;
               expired = (tbl_kind[i] == KIND_DIRECT && tbl_age[i] > direct_limit) ||
                         (tbl_kind[i] == KIND_VIA && tbl_age[i] > indirect_limit);
               if (expired) retire_route(i);
            end
         end
         CMD_NONE: begin
         end
      endcase
      foreach (prior[i]) begin
         if (prior[i] != tbl_kind[i] && r.changed != CNT_MAX) r.changed = r.changed + 1'b1;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------------------------
   // channel drivers and response checking
   // ---------------------------------------------------------------------------------------

   function automatic route_cmd_type route_op(input cmd_type command,
                                              input logic [ADDR_W-1:0] dest,
                                              input logic [PREFIX_W-1:0] prefix,
                                              input logic [ADDR_W-1:0] hop,
                                              input logic [DIST_W-1:0] distance,
                                              input kind_type kind,
                                              input logic [AGE_W-1:0] age);
      route_cmd_type c;
      c.command        = command;
      c.dest_ip        = dest;
      c.dest_prefix    = prefix;
      c.next_hop_ip    = hop;
      c.route_distance = distance;
      c.route_kind     = kind;
      c.initial_age    = age;
      return c;
   endfunction

   // small address pool so adds, invalidates and next hops keep hitting each other
   function automatic logic [ADDR_W-1:0] pool_address(input int idx);
      if (idx == 0) return '0;
      if (idx == 9) return '1;
      return ADDR_W'(32'hC0A8_0100 + idx);
   endfunction

   // one transaction on the request channel; valid stays high after acceptance so the
   // next call can present a new item without dropping it in the same step
   task automatic send_route_command(input route_cmd_type c);
      if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
      req_bus.valid          <= 1'b1;
      req_bus.command        <= c.command;
      req_bus.dest_ip        <= c.dest_ip;
      req_bus.dest_prefix    <= c.dest_prefix;
      req_bus.next_hop_ip    <= c.next_hop_ip;
      req_bus.route_distance <= c.route_distance;
      req_bus.route_kind     <= c.route_kind;
      req_bus.initial_age    <= c.initial_age;
      do @(posedge clock); while (!req_bus.ready);
      pending_results.push_back(predict_route_result(c));
   endtask

   // drop valid, wait for every owed response, then let the block settle
   task automatic wait_until_drained(input int settle);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // limit register write, only issued while the block is idle
   task automatic write_limit(input logic [CSR_IDX_W-1:0] index,
                              input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (index == CSR_DIRECT_AGE_LIMIT) direct_limit = value;
      else indirect_limit = value;
   endtask

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // compare each accepted response with the oldest prediction
   always @(posedge clock) begin : check_results
      route_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response: status %0d slot_index %0d changed_count %0d",
                   rsp_bus.status, rsp_bus.slot_index, rsp_bus.changed_count);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
               mismatch_count++;
            end
            if (rsp_bus.slot_index !== want.slot) begin
               $error("slot_index: expected %0d, got %0d", want.slot, rsp_bus.slot_index);
               mismatch_count++;
            end
            if (rsp_bus.changed_count !== want.changed) begin
               $error("changed_count: expected %0d, got %0d",
                      want.changed, rsp_bus.changed_count);
               mismatch_count++;
            end
         end
      end
   end

   // hang detection: cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT_CYCLES) begin
            $display("tb_distance_vector_route_table: errors");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------------

   // add: new entry, kept on longer distance, replaced on same hop or equal distance,
   // free entries matched by address, free kind stored as given
   task automatic test_add_replace;
      send_route_command(route_op(CMD_TICK, $urandom, 6'd0, $urandom, $urandom,
                                  KIND_DIRECT, 8'd0));
      send_route_command(route_op(CMD_ADD, 32'h0A00_0001, 6'd24, 32'h0A00_00FE, 32'd10,
                                  KIND_DIRECT, 8'd0));
      send_route_command(route_op(CMD_ADD, 32'h0A00_0001, 6'd24, 32'h0A00_0077, 32'd20,
                                  KIND_DIRECT, 8'd1));
      send_route_command(route_op(CMD_ADD, 32'h0A00_0001, 6'd24, 32'h0A00_00FE, 32'd30,
                                  KIND_DIRECT, 8'd2));
      send_route_command(route_op(CMD_ADD, 32'h0A00_0001, 6'd24, 32'h0A00_0055, 32'd30,
                                  KIND_DIRECT, 8'd0));
      // address zero hits entry zero, still free with address zero
      send_route_command(route_op(CMD_ADD, 32'h0000_0000, 6'd0, 32'h0000_0000, 32'd0,
                                  KIND_FREE, 8'd0));
      send_route_command(route_op(CMD_ADD, 32'hC0A8_0001, 6'd32, 32'h0A00_0001,
                                  32'hFFFF_FFFF, KIND_VIA, 8'hFF));
   endtask

   // invalidate: direct route goes unreachable and frees its dependents, via route freed,
   // prefix must match, unreachable entry replaced by a longer add
   task automatic test_invalidate;
      send_route_command(route_op(CMD_INVAL, 32'h0A00_0001, 6'd24, $urandom, $urandom,
                                  KIND_FREE, 8'd0));
      send_route_command(route_op(CMD_ADD, 32'hFFFF_FFFF, 6'd63, 32'h1234_5678, 32'd3,
                                  KIND_UNREACH, 8'd7));
      send_route_command(route_op(CMD_ADD, 32'hFFFF_FFFF, 6'd63, 32'h9ABC_DEF0, 32'd9,
                                  KIND_VIA, 8'd0));
      send_route_command(route_op(CMD_INVAL, 32'hFFFF_FFFF, 6'd63, $urandom, $urandom,
                                  KIND_UNREACH, 8'd0));
      send_route_command(route_op(CMD_INVAL, 32'h0A00_0001, 6'd0, $urandom, $urandom,
                                  KIND_VIA, 8'd0));
   endtask

   // tick: aging with saturation, direct expiry cascading onto a lower entry through it
   task automatic test_tick_aging;
      wait_until_drained(CONFIG_SETTLE);
      write_limit(CSR_DIRECT_AGE_LIMIT, 8'd1);
      write_limit(CSR_INDIRECT_AGE_LIMIT, 8'd255);
      send_route_command(route_op(CMD_ADD, 32'h0102_0304, 6'd32, 32'h0000_0000, 32'd1,
                                  KIND_DIRECT, 8'd0));
      send_route_command(route_op(CMD_ADD, 32'h0506_0708, 6'd16, 32'h0102_0304, 32'd2,
                                  KIND_VIA, 8'hFF));
      send_route_command(route_op(CMD_ADD, 32'h7F00_0001, 6'd8, 32'h0000_0000, 32'd0,
                                  KIND_DIRECT, 8'hFF));
      send_route_command(route_op(CMD_TICK, $urandom, 6'd0, $urandom, $urandom,
                                  KIND_FREE, 8'd0));
      send_route_command(route_op(CMD_TICK, $urandom, 6'd0, $urandom, $urandom,
                                  KIND_FREE, 8'd0));
   endtask

   // fill every free entry, then the remaining adds report the table full; unused command too
   task automatic test_full_table;
      for (int i = 1; i <= 7; i++) begin
         send_route_command(route_op(CMD_ADD, ADDR_W'(32'h0B00_0000 + i), 6'd24,
                                     32'h0B00_0000, DIST_W'(i), KIND_DIRECT, 8'd0));
      end
      send_route_command(route_op(CMD_NONE, $urandom, 6'h3F, $urandom, $urandom,
                                  KIND_UNREACH, 8'hFF));
   endtask

   // mostly well-formed traffic over a small address pool, with some raw noise
   task automatic test_random_traffic(input int count);
      route_cmd_type c;
      int pick;
      int idx;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            c = route_op(cmd_type'($urandom_range(0, 3)), $urandom,
                         PREFIX_W'($urandom_range(0, 63)), $urandom, $urandom,
                         kind_type'($urandom_range(0, 3)), AGE_W'($urandom_range(0, 255)));
         end else begin
            idx           = $urandom_range(0, 9);
            c.dest_ip     = pool_address(idx);
            c.dest_prefix = ($urandom_range(0, 99) < 85) ? PREFIX_W'(24)
                                                         : PREFIX_W'($urandom_range(0, 63));
            c.next_hop_ip = $urandom_range(0, 1) ? pool_address($urandom_range(0, 9))
                                                 : ADDR_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 45)      c.command = CMD_ADD;
            else if (pick < 65) c.command = CMD_INVAL;
            else if (pick < 95) c.command = CMD_TICK;
            else                c.command = CMD_NONE;
            pick = $urandom_range(0, 99);
            if (pick < 80)      c.route_distance = DIST_W'($urandom_range(0, 15));
            else if (pick < 90) c.route_distance = '1;
            else                c.route_distance = DIST_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 40)      c.route_kind = KIND_DIRECT;
            else if (pick < 80) c.route_kind = KIND_VIA;
            else if (pick < 90) c.route_kind = KIND_UNREACH;
            else                c.route_kind = KIND_FREE;
            pick = $urandom_range(0, 99);
            if (pick < 85)      c.initial_age = AGE_W'($urandom_range(0, 6));
            else if (pick < 95) c.initial_age = AGE_W'($urandom_range(0, 255));
            else                c.initial_age = AGE_MAX;
         end
         send_route_command(c);
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------------------------

   initial begin
      // every request input known from time zero, reset held before the first command
      reset                  <= 1'b1;
      csr_we                 <= 1'b0;
      csr_index              <= '0;
      csr_wdata              <= '0;
      req_bus.valid          <= 1'b0;
      req_bus.command        <= CMD_ADD;
      req_bus.dest_ip        <= '0;
      req_bus.dest_prefix    <= '0;
      req_bus.next_hop_ip    <= '0;
      req_bus.route_distance <= '0;
      req_bus.route_kind     <= KIND_FREE;
      req_bus.initial_age    <= '0;
      mismatch_count     = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      direct_limit       = DIRECT_AGE_RESET;
      indirect_limit     = INDIRECT_AGE_RESET;
      foreach (tbl_kind[i]) begin
         tbl_dest[i]   = '0;
         tbl_prefix[i] = '0;
         tbl_hop[i]    = '0;
         tbl_dist[i]   = '0;
         tbl_kind[i]   = KIND_FREE;
         tbl_age[i]    = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part, no idling; reset limits until the tick test sets its own
      test_add_replace;
      test_invalidate;
      test_tick_aging;
      test_full_table;

      // random phases: each sets its limits and one of four idling patterns
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_until_drained(CONFIG_SETTLE);
         case (phase)
            0: begin
               write_limit(CSR_DIRECT_AGE_LIMIT, DIRECT_AGE_RESET);
               write_limit(CSR_INDIRECT_AGE_LIMIT, INDIRECT_AGE_RESET);
            end
            1: begin
               write_limit(CSR_DIRECT_AGE_LIMIT, 8'd0);
               write_limit(CSR_INDIRECT_AGE_LIMIT, 8'd0);
            end
            2: begin
               write_limit(CSR_DIRECT_AGE_LIMIT, 8'd255);
               write_limit(CSR_INDIRECT_AGE_LIMIT, 8'd255);
            end
            3: begin
               write_limit(CSR_DIRECT_AGE_LIMIT, 8'd1);
               write_limit(CSR_INDIRECT_AGE_LIMIT, 8'd0);
            end
            4: begin
               write_limit(CSR_DIRECT_AGE_LIMIT, 8'd0);
               write_limit(CSR_INDIRECT_AGE_LIMIT, 8'd255);
            end
            5: begin
               write_limit(CSR_DIRECT_AGE_LIMIT, 8'd255);
               write_limit(CSR_INDIRECT_AGE_LIMIT, 8'd3);
            end
            default: begin
               write_limit(CSR_DIRECT_AGE_LIMIT, CSR_DATA_W'($urandom_range(0, 8)));
               write_limit(CSR_INDIRECT_AGE_LIMIT, CSR_DATA_W'($urandom_range(0, 8)));
            end
         endcase
         // idling: none, sender gaps, receiver stalls, light both
         case (phase % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 53;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 53;
            end
            default: begin
               sender_idle_pct    = 9;
               receiver_stall_pct = 9;
            end
         endcase
         test_random_traffic(PHASE_ITEMS);
      end

      // drain and settle, then verdict
      wait_until_drained(END_SETTLE);
      if (pending_results.size() != 0) begin
         $error("%0d responses never arrived", pending_results.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("tb_distance_vector_route_table: clean");
      end else begin
         $display("tb_distance_vector_route_table: errors");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/dvrt_pkg.sv
rtl/dvrt_req_if.sv
rtl/dvrt_rsp_if.sv
rtl/dvrt_ram.sv
rtl/distance_vector_route_table.sv
verif/tb_distance_vector_route_table.sv
